FILE: rtl/bplw_pkg.sv
// Shared types, constants and helpers for the Bresenham line pixel writer.
`timescale 1ns / 1ps
package bplw_pkg;

  // Default sizing of the coordinate path and the frame address
  localparam int COORD_BITS_DEFAULT = 14;
  localparam int ADDR_BITS_DEFAULT  = 24;

  // Configuration port geometry
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  // Fixed register field widths
  localparam int FRAME_DIM_W = 13;
  localparam int STRIDE_W    = 14;
  localparam int BASE_W      = 24;
  localparam int FORMAT_W    = 9;
  localparam int LEVEL_W     = 8;
  localparam int WORD_W      = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BASE_OFFSET  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RED_FORMAT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_FORMAT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_FORMAT  = 3'd6;

  // Register reset values
  localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd1024;
  localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd1024;
  localparam logic [STRIDE_W-1:0]    ROW_STRIDE_RST   = 14'd1024;
  localparam logic [BASE_W-1:0]      BASE_OFFSET_RST  = 24'd0;
  localparam logic [FORMAT_W-1:0]    RED_FORMAT_RST   = 9'd264;
  localparam logic [FORMAT_W-1:0]    GREEN_FORMAT_RST = 9'd136;
  localparam logic [FORMAT_W-1:0]    BLUE_FORMAT_RST  = 9'd8;

  // Operation codes of an input item
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Widest channel size honored by the color packer
  localparam logic [3:0] CHANNEL_MAX_SIZE = 4'd8;

  // Current configuration as seen by the datapath
  typedef struct packed {
    logic [FRAME_DIM_W-1:0] frame_width;
    logic [FRAME_DIM_W-1:0] frame_height;
    logic [STRIDE_W-1:0]    row_stride;
    logic [BASE_W-1:0]      base_offset;
    logic [FORMAT_W-1:0]    red_format;
    logic [FORMAT_W-1:0]    green_format;
    logic [FORMAT_W-1:0]    blue_format;
  } cfg_t;

  // Walker to output stage control
  typedef struct packed {
    logic emit;
    logic last;
  } pix_ctl_t;

  // Place one 8-bit level into the 32-bit word: keep the top size bits, then shift to offset
  function automatic logic [WORD_W-1:0] pack_channel(input logic [LEVEL_W-1:0] level,
                                                     input logic [FORMAT_W-1:0] fmt);
    logic [3:0]         size;
    logic [4:0]         offset;
    logic [LEVEL_W-1:0] chan;
    size   = (fmt[3:0] > CHANNEL_MAX_SIZE) ? CHANNEL_MAX_SIZE : fmt[3:0];
    offset = fmt[8:4];
    chan   = level >> (CHANNEL_MAX_SIZE - size);
    return {{(WORD_W-LEVEL_W){1'b0}}, chan} << offset;
  endfunction

endpackage

FILE: rtl/bresenham_line_pixel_writer_unit.sv
// Top level of the Bresenham line pixel writer.
// One input item is taken every clock unless a pixel sits stalled in the output register. A start
// item loads the endpoints and packs the color and gives no pixel; each step item on an active
// line gives one pixel, registered and shown on the cycle after it is taken, and the walk state is
// ready for the next step at once. The rate is set by the per-step path from the walk registers
// through the y * row_stride multiply and the address add into the output register. A new item
// is taken whenever the output register is empty or is being drained.
`timescale 1ns / 1ps
module bresenham_line_pixel_writer_unit #(
  parameter int COORD_BITS = bplw_pkg::COORD_BITS_DEFAULT,
  parameter int ADDR_BITS  = bplw_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bplw_pkg::PADDR_W-1:0] paddr,
  input  logic [bplw_pkg::PDATA_W-1:0] pwdata,
  output logic [bplw_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [bplw_pkg::LEVEL_W-1:0] red,
  input  logic [bplw_pkg::LEVEL_W-1:0] green,
  input  logic [bplw_pkg::LEVEL_W-1:0] blue,
  // pixel items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pixel_write,
  output logic [ADDR_BITS-1:0]         pixel_address,
  output logic [bplw_pkg::WORD_W-1:0]  pixel_value,
  output logic                         last_pixel
);
  import bplw_pkg::*;

  cfg_t                  cfg;
  pix_ctl_t              ctl;
  logic [COORD_BITS-1:0] point_x, point_y;
  logic [WORD_W-1:0]     point_color;
  logic                  in_fire;

  // Take an item whenever the output register can accept a pixel
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  bplw_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bplw_line_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .operation   (operation),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .cfg         (cfg),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_color (point_color),
    .ctl         (ctl)
  );

  bplw_pixel_stage #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_pixel (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_color   (point_color),
    .ctl           (ctl),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .pixel_write   (pixel_write),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .last_pixel    (last_pixel)
  );

endmodule

FILE: rtl/bplw_cfg_regs.sv
// APB-style configuration registers of the line pixel writer.
`timescale 1ns / 1ps
module bplw_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bplw_pkg::PADDR_W-1:0] paddr,
  input  logic [bplw_pkg::PDATA_W-1:0] pwdata,
  output logic [bplw_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output bplw_pkg::cfg_t               cfg
);
  import bplw_pkg::*;

  cfg_t                 regs;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];
  assign cfg    = regs;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_width  <= FRAME_WIDTH_RST;
      regs.frame_height <= FRAME_HEIGHT_RST;
      regs.row_stride   <= ROW_STRIDE_RST;
      regs.base_offset  <= BASE_OFFSET_RST;
      regs.red_format   <= RED_FORMAT_RST;
      regs.green_format <= GREEN_FORMAT_RST;
      regs.blue_format  <= BLUE_FORMAT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_WIDTH:  regs.frame_width  <= pwdata[FRAME_DIM_W-1:0];
        REG_FRAME_HEIGHT: regs.frame_height <= pwdata[FRAME_DIM_W-1:0];
        REG_ROW_STRIDE:   regs.row_stride   <= pwdata[STRIDE_W-1:0];
        REG_BASE_OFFSET:  regs.base_offset  <= pwdata[BASE_W-1:0];
        REG_RED_FORMAT:   regs.red_format   <= pwdata[FORMAT_W-1:0];
        REG_GREEN_FORMAT: regs.green_format <= pwdata[FORMAT_W-1:0];
        REG_BLUE_FORMAT:  regs.blue_format  <= pwdata[FORMAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = {{(PDATA_W-FRAME_DIM_W){1'b0}}, regs.frame_width};
      REG_FRAME_HEIGHT: prdata = {{(PDATA_W-FRAME_DIM_W){1'b0}}, regs.frame_height};
      REG_ROW_STRIDE:   prdata = {{(PDATA_W-STRIDE_W){1'b0}}, regs.row_stride};
      REG_BASE_OFFSET:  prdata = {{(PDATA_W-BASE_W){1'b0}}, regs.base_offset};
      REG_RED_FORMAT:   prdata = {{(PDATA_W-FORMAT_W){1'b0}}, regs.red_format};
      REG_GREEN_FORMAT: prdata = {{(PDATA_W-FORMAT_W){1'b0}}, regs.green_format};
      REG_BLUE_FORMAT:  prdata = {{(PDATA_W-FORMAT_W){1'b0}}, regs.blue_format};
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bplw_line_walker.sv
// Line state: endpoint setup on start, one Bresenham step per accepted step item on an active line.
`timescale 1ns / 1ps
module bplw_line_walker #(
  parameter int COORD_BITS = bplw_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_fire,
  input  logic                                 operation,
  input  logic signed [COORD_BITS-1:0]         start_x,
  input  logic signed [COORD_BITS-1:0]         start_y,
  input  logic signed [COORD_BITS-1:0]         end_x,
  input  logic signed [COORD_BITS-1:0]         end_y,
  input  logic [bplw_pkg::LEVEL_W-1:0]         red,
  input  logic [bplw_pkg::LEVEL_W-1:0]         green,
  input  logic [bplw_pkg::LEVEL_W-1:0]         blue,
  input  bplw_pkg::cfg_t                       cfg,
  output logic [COORD_BITS-1:0]                point_x,
  output logic [COORD_BITS-1:0]                point_y,
  output logic [bplw_pkg::WORD_W-1:0]          point_color,
  output bplw_pkg::pix_ctl_t                   ctl
);
  import bplw_pkg::*;

  localparam int ERR_W  = COORD_BITS + 3;
  localparam int LEFT_W = COORD_BITS + 1;

  // Line state
  logic                    line_active;
  logic [COORD_BITS-1:0]   cur_x, cur_y;
  logic signed [ERR_W-1:0] error_term;
  logic [COORD_BITS-1:0]   delta_x, delta_y;
  logic                    x_descending, y_descending, x_is_major;
  logic [LEFT_W-1:0]       pixels_left;
  logic [WORD_W-1:0]       color_word;

  // Start setup
  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [COORD_BITS-1:0]      abs_x, abs_y, major_len;
  logic                       start_x_major;
  logic [ERR_W-1:0]           err_start;
  logic [LEFT_W-1:0]          left_start;
  logic [WORD_W-1:0]          color_start;

  // Step update
  logic                    is_start, is_step, last;
  logic [ERR_W-1:0]        two_dx, two_dy;
  logic signed [ERR_W-1:0] err_acc, err_next;
  logic                    take_minor;
  logic [COORD_BITS-1:0]   x_stepped, y_stepped, cur_x_next, cur_y_next;

  assign is_start = in_fire && (operation == OP_START);
  assign is_step  = in_fire && (operation == OP_STEP) && line_active;

  // Deltas, directions and color for a new line
  always_comb begin
    diff_x        = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    diff_y        = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    abs_x         = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    abs_y         = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    start_x_major = abs_x > abs_y;
    major_len     = start_x_major ? abs_x : abs_y;
    err_start     = ERR_W'(0) - {3'b000, major_len};
    left_start    = {1'b0, major_len} + LEFT_W'(1);
    color_start   = pack_channel(red, cfg.red_format)
                  | pack_channel(green, cfg.green_format)
                  | pack_channel(blue, cfg.blue_format);
  end

  // One Bresenham step: major axis always moves, minor when the error is not negative
  always_comb begin
    two_dx     = {2'b00, delta_x, 1'b0};
    two_dy     = {2'b00, delta_y, 1'b0};
    err_acc    = error_term + $signed(x_is_major ? two_dy : two_dx);
    take_minor = !err_acc[ERR_W-1];
    err_next   = take_minor ? err_acc - $signed(x_is_major ? two_dx : two_dy) : err_acc;
    x_stepped  = x_descending ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
    y_stepped  = y_descending ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
    cur_x_next = (x_is_major || take_minor) ? x_stepped : cur_x;
    cur_y_next = (!x_is_major || take_minor) ? y_stepped : cur_y;
    last       = pixels_left <= LEFT_W'(1);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (is_start) begin
      line_active <= 1'b1;
    end else if (is_step && last) begin
      line_active <= 1'b0;
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (is_start) begin
      cur_x        <= start_x;
      cur_y        <= start_y;
      delta_x      <= abs_x;
      delta_y      <= abs_y;
      x_descending <= !(end_x > start_x);
      y_descending <= !(end_y > start_y);
      x_is_major   <= start_x_major;
      error_term   <= $signed(err_start);
      pixels_left  <= left_start;
      color_word   <= color_start;
    end else if (is_step) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      error_term  <= err_next;
      pixels_left <= last ? '0 : pixels_left - LEFT_W'(1);
    end
  end

  // The point emitted is the one before the step
  assign point_x     = cur_x;
  assign point_y     = cur_y;
  assign point_color = color_word;
  assign ctl.emit    = is_step;
  assign ctl.last    = last;

endmodule

FILE: rtl/bplw_pixel_stage.sv
// Clip test, frame address and the registered pixel output.
`timescale 1ns / 1ps
module bplw_pixel_stage #(
  parameter int COORD_BITS = bplw_pkg::COORD_BITS_DEFAULT,
  parameter int ADDR_BITS  = bplw_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bplw_pkg::cfg_t              cfg,
  input  logic [COORD_BITS-1:0]       point_x,
  input  logic [COORD_BITS-1:0]       point_y,
  input  logic [bplw_pkg::WORD_W-1:0] point_color,
  input  bplw_pkg::pix_ctl_t          ctl,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        pixel_write,
  output logic [ADDR_BITS-1:0]        pixel_address,
  output logic [bplw_pkg::WORD_W-1:0] pixel_value,
  output logic                        last_pixel
);
  import bplw_pkg::*;

  localparam int MAG_W  = COORD_BITS - 1;
  localparam int PROD_W = MAG_W + STRIDE_W;
  localparam int SUM_W  = PROD_W + ADDR_BITS + BASE_W;

  logic              x_in, y_in, in_frame;
  logic [PROD_W-1:0] row_off;
  logic [SUM_W-1:0]  addr_sum;
  logic [ADDR_BITS-1:0] addr;

  // Clip: both coordinates non-negative and below the frame size
  always_comb begin
    x_in     = !point_x[COORD_BITS-1] &&
               ({{FRAME_DIM_W{1'b0}}, point_x} < {{COORD_BITS{1'b0}}, cfg.frame_width});
    y_in     = !point_y[COORD_BITS-1] &&
               ({{FRAME_DIM_W{1'b0}}, point_y} < {{COORD_BITS{1'b0}}, cfg.frame_height});
    in_frame = x_in && y_in;
  end

  // base + y * stride + x, kept to the address width
  always_comb begin
    row_off  = PROD_W'(point_y[MAG_W-1:0]) * PROD_W'(cfg.row_stride);
    addr_sum = SUM_W'(cfg.base_offset) + SUM_W'(row_off) + SUM_W'(point_x[MAG_W-1:0]);
    addr     = in_frame ? addr_sum[ADDR_BITS-1:0] : '0;
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pixel_write   <= in_frame;
      pixel_address <= addr;
      pixel_value   <= point_color;
      last_pixel    <= ctl.last;
    end
  end

endmodule

FILE: rtl/bplw_checker.sv
// Port-level checks for the line pixel writer, bound to the top level.
`timescale 1ns / 1ps
module bplw_checker #(
  parameter int ADDR_BITS = bplw_pkg::ADDR_BITS_DEFAULT
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        pixel_write,
  input logic [ADDR_BITS-1:0]        pixel_address,
  input logic [bplw_pkg::WORD_W-1:0] pixel_value,
  input logic                        last_pixel
);
  import bplw_pkg::*;

  // A pending pixel stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel dropped before it was taken");

  // A stalled pixel keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_address) && $stable(pixel_value) &&
                               $stable(pixel_write) && $stable(last_pixel))
    else $error("stalled pixel payload changed");

  // No item is taken while a pixel sits stalled
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while the output register is full");

  // A start item never gives a pixel
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_START |=> !out_valid)
    else $error("pixel after a start item");

  // A fresh pixel only follows an accepted step item
  a_step_source: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && operation == OP_STEP) && (!out_valid || out_ready)
    |=> !out_valid)
    else $error("pixel without a step item");

endmodule

bind bresenham_line_pixel_writer_unit bplw_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_bplw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .operation     (operation),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pixel_write   (pixel_write),
  .pixel_address (pixel_address),
  .pixel_value   (pixel_value),
  .last_pixel    (last_pixel)
);

FILE: tb/bresenham_line_pixel_writer_unit_test.sv
// Self-checking testbench for the Bresenham line pixel writer: line walks against a local predictor.
`timescale 1ns / 1ps
module bresenham_line_pixel_writer_unit_test;
  import bplw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int COORD_MIN   = -8192;
  localparam int COORD_MAX   = 8191;

  // one input item as it goes on the wire
  typedef struct {
    logic                op;
    logic signed [13:0]  sx;
    logic signed [13:0]  sy;
    logic signed [13:0]  ex;
    logic signed [13:0]  ey;
    logic [7:0]          r;
    logic [7:0]          g;
    logic [7:0]          b;
  } line_item_t;

  // one pixel item
  typedef struct {
    logic        write;
    logic [23:0] addr;
    logic [31:0] value;
    logic        last;
  } pixel_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic operation;
  logic signed [13:0] start_x;
  logic signed [13:0] start_y;
  logic signed [13:0] end_x;
  logic signed [13:0] end_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic out_valid;
  logic out_ready;
  logic pixel_write;
  logic [23:0] pixel_address;
  logic [31:0] pixel_value;
  logic last_pixel;

  bresenham_line_pixel_writer_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_write(pixel_write),
    .pixel_address(pixel_address), .pixel_value(pixel_value), .last_pixel(last_pixel)
  );

  // configuration copy
  logic [12:0] fb_width;
  logic [12:0] fb_height;
  logic [13:0] fb_stride;
  logic [23:0] fb_base;
  logic [8:0]  fmt_red;
  logic [8:0]  fmt_green;
  logic [8:0]  fmt_blue;

  // walk state copy
  bit                 walking;
  logic signed [13:0] walk_x;
  logic signed [13:0] walk_y;
  int                 walk_err;
  int                 span_x;
  int                 span_y;
  bit                 x_down;
  bit                 y_down;
  bit                 x_major;
  int                 points_left;
  logic [31:0]        line_color;

  line_item_t pending_items[$];
  pixel_t     expected_pixels[$];
  line_item_t drive_item;
  pixel_t     seen_pixel;
  pixel_t     want_pixel;

  int src_gap;
  int sink_stall;
  bit src_gaps_on;
  int stall_level;
  int errors;
  int lines_started;
  int pixels_checked;
  int clipped_pixels;
  int settings_used;
  int phase_items;
  int unsigned cycle_count;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // keep the top size bits of a level and place them at the channel offset
  function automatic logic [31:0] shade_channel(input logic [7:0] level, input logic [8:0] fmt);
    int          bits;
    logic [31:0] w;
    bits = int'(fmt[3:0]);
    if (bits > 8) bits = 8;
    w = {24'b0, level} >> (8 - bits);
    return w << fmt[8:4];
  endfunction

  // predictor: apply one accepted item, queue the pixel it gives
  function automatic void rasterize_item(input line_item_t it);
    int     x0, y0, x1, y1, dx, dy, sx, sy;
    longint lin;
    pixel_t px;
    if (it.op == OP_START) begin
      x0 = it.sx; y0 = it.sy; x1 = it.ex; y1 = it.ey;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      walk_x = it.sx;
      walk_y = it.sy;
      span_x = dx;
      span_y = dy;
      x_down = !(x1 > x0);
      y_down = !(y1 > y0);
      x_major = dx > dy;
      walk_err = x_major ? -dx : -dy;
      points_left = (x_major ? dx : dy) + 1;
      line_color = shade_channel(it.r, fmt_red) | shade_channel(it.g, fmt_green) |
                   shade_channel(it.b, fmt_blue);
      walking = 1'b1;
      lines_started++;
    end else if (walking) begin
      x0 = walk_x;
      y0 = walk_y;
      px.write = x0 >= 0 && y0 >= 0 && x0 < int'(fb_width) && y0 < int'(fb_height);
      lin = longint'(fb_base) + longint'(y0) * longint'(fb_stride) + longint'(x0);
      px.addr = px.write ? lin[23:0] : 24'd0;
      px.value = line_color;
      px.last = points_left <= 1;
      sx = x_down ? -1 : 1;
      sy = y_down ? -1 : 1;
      if (x_major) begin
        walk_x = 14'(x0 + sx);
        walk_err += 2 * span_y;
        if (walk_err >= 0) begin
          walk_y = 14'(y0 + sy);
          walk_err -= 2 * span_x;
        end
      end else begin
        walk_y = 14'(y0 + sy);
        walk_err += 2 * span_x;
        if (walk_err >= 0) begin
          walk_x = 14'(x0 + sx);
          walk_err -= 2 * span_y;
        end
      end
      if (px.last) begin
        walking = 1'b0;
        points_left = 0;
      end else begin
        points_left--;
      end
      expected_pixels.push_back(px);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!src_gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (stall_level == 0) return 0;
    if (stall_level == 2) return (r < 40) ? 0 : ((r < 85) ? $urandom_range(1, 8) :
                                                           $urandom_range(20, 40));
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready) rasterize_item(drive_item);
      if (in_valid && !in_ready) begin
        // hold the item until it is taken
      end else if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        drive_item = pending_items.pop_front();
        operation <= drive_item.op;
        start_x <= drive_item.sx;
        start_y <= drive_item.sy;
        end_x <= drive_item.ex;
        end_y <= drive_item.ey;
        red <= drive_item.r;
        green <= drive_item.g;
        blue <= drive_item.b;
        in_valid <= 1'b1;
        src_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // pixel monitor and sink stalls
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_pixel.write = pixel_write;
      seen_pixel.addr = pixel_address;
      seen_pixel.value = pixel_value;
      seen_pixel.last = last_pixel;
      if (expected_pixels.size() == 0) begin
        $error("pixel item with none expected: address %h value %h",
               seen_pixel.addr, seen_pixel.value);
        errors++;
      end else begin
        want_pixel = expected_pixels.pop_front();
        pixels_checked++;
        if (!want_pixel.write) clipped_pixels++;
        if (seen_pixel.write !== want_pixel.write) begin
          $error("pixel_write: expected %0d, got %0d", want_pixel.write, seen_pixel.write);
          errors++;
        end
        if (seen_pixel.addr !== want_pixel.addr) begin
          $error("pixel_address: expected %h, got %h", want_pixel.addr, seen_pixel.addr);
          errors++;
        end
        if (seen_pixel.value !== want_pixel.value) begin
          $error("pixel_value: expected %h, got %h", want_pixel.value, seen_pixel.value);
          errors++;
        end
        if (seen_pixel.last !== want_pixel.last) begin
          $error("last_pixel: expected %0d, got %0d", want_pixel.last, seen_pixel.last);
          errors++;
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
      sink_stall = 0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      sink_stall = pick_stall();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // register write over the config port, mirrored into the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  fb_width = value[12:0];
      REG_FRAME_HEIGHT: fb_height = value[12:0];
      REG_ROW_STRIDE:   fb_stride = value[13:0];
      REG_BASE_OFFSET:  fb_base = value[23:0];
      REG_RED_FORMAT:   fmt_red = value[8:0];
      REG_GREEN_FORMAT: fmt_green = value[8:0];
      REG_BLUE_FORMAT:  fmt_blue = value[8:0];
      default: ;
    endcase
  endtask

  // wait until every item is taken and every pixel has come, then a short tail
  task automatic drain(input int tail);
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic load_setting(input logic [31:0] w, input logic [31:0] h, input logic [31:0] s,
                              input logic [31:0] base, input logic [31:0] fr,
                              input logic [31:0] fg, input logic [31:0] fbl);
    drain(4);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_ROW_STRIDE, s);
    write_reg(REG_BASE_OFFSET, base);
    write_reg(REG_RED_FORMAT, fr);
    write_reg(REG_GREEN_FORMAT, fg);
    write_reg(REG_BLUE_FORMAT, fbl);
    settings_used++;
    phase_items = 0;
  endtask

  function automatic line_item_t random_item();
    line_item_t it;
    it.op = 1'($urandom_range(0, 1));
    it.sx = 14'($urandom);
    it.sy = 14'($urandom);
    it.ex = 14'($urandom);
    it.ey = 14'($urandom);
    it.r = 8'($urandom);
    it.g = 8'($urandom);
    it.b = 8'($urandom);
    return it;
  endfunction

  function automatic logic signed [13:0] fit_coord(input int v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return 14'(v);
  endfunction

  // coordinate mostly inside or just around the frame, sometimes anywhere
  function automatic int pick_coord(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return int'($urandom_range(0, lim + 4)) - 4;
    if (r < 88) return lim + int'($urandom_range(0, 6)) - 3;
    return int'($urandom_range(0, 16383)) - 8192;
  endfunction

  task automatic push_start(input int x0, input int y0, input int x1, input int y1,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    line_item_t it;
    it = random_item();
    it.op = OP_START;
    it.sx = fit_coord(x0);
    it.sy = fit_coord(y0);
    it.ex = fit_coord(x1);
    it.ey = fit_coord(y1);
    it.r = r;
    it.g = g;
    it.b = b;
    pending_items.push_back(it);
    phase_items++;
  endtask

  task automatic push_steps(input int count);
    line_item_t it;
    repeat (count) begin
      it = random_item();
      it.op = OP_STEP;
      pending_items.push_back(it);
      phase_items++;
    end
  endtask

  // one random line: mostly a full walk, sometimes cut short, overrun or noise
  task automatic add_line();
    int kind, x0, y0, x1, y1, reach, n, dx, dy;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      pending_items.push_back(random_item());
      phase_items++;
    end else if (kind < 13) begin
      push_start(int'($urandom_range(0, 16383)) - 8192, int'($urandom_range(0, 16383)) - 8192,
                 int'($urandom_range(0, 16383)) - 8192, int'($urandom_range(0, 16383)) - 8192,
                 8'($urandom), 8'($urandom), 8'($urandom));
      push_steps($urandom_range(0, 30));
    end else begin
      x0 = fit_coord(pick_coord(fb_width));
      y0 = fit_coord(pick_coord(fb_height));
      reach = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 60);
      x1 = fit_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
      y1 = fit_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      n = ((dx > dy) ? dx : dy) + 1;
      kind = $urandom_range(0, 99);
      if (kind < 10) n = $urandom_range(0, n - 1);
      else if (kind < 20) n += $urandom_range(1, 3);
      push_start(x0, y0, x1, y1, 8'($urandom), 8'($urandom), 8'($urandom));
      push_steps(n);
    end
    // now and then the sender waits for every pixel to come back
    if ($urandom_range(0, 99) < 3) drain(0);
  endtask

  task automatic random_phase(input int count);
    while (phase_items < count) add_line();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    operation = OP_STEP;
    start_x = '0;
    start_y = '0;
    end_x = '0;
    end_y = '0;
    red = '0;
    green = '0;
    blue = '0;
    out_ready = 1'b0;
    src_gaps_on = 1'b1;
    stall_level = 1;
    errors = 0;
    cycle_count = 0;
    settings_used = 1;
    fb_width = FRAME_WIDTH_RST;
    fb_height = FRAME_HEIGHT_RST;
    fb_stride = ROW_STRIDE_RST;
    fb_base = BASE_OFFSET_RST;
    fmt_red = RED_FORMAT_RST;
    fmt_green = GREEN_FORMAT_RST;
    fmt_blue = BLUE_FORMAT_RST;
    walking = 1'b0;
    walk_x = '0;
    walk_y = '0;
    walk_err = 0;
    span_x = 0;
    span_y = 0;
    x_down = 1'b0;
    y_down = 1'b0;
    x_major = 1'b0;
    points_left = 0;
    line_color = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed lines at reset settings
    push_steps(1);                                         // step with no line active
    push_start(0, 0, 0, 0, 8'hff, 8'hff, 8'hff);           // single point, then an idle step
    push_steps(2);
    push_start(-8192, -8192, 8191, 8191, 8'h00, 8'h00, 8'h00);
    push_steps(2);                                         // longest line, abandoned below
    push_start(5, 3, 0, 1, 8'hff, 8'h00, 8'h80);           // x major, both descending
    push_steps(6);
    push_start(1020, 1021, 1026, 1027, 8'h12, 8'hff, 8'h00); // diagonal running out of frame
    push_steps(7);
    push_start(8191, -8192, 8191, -8192, 8'h00, 8'h00, 8'hff); // clipped single point
    push_steps(1);

    // reset settings, random lines
    random_phase(200);

    // widest frame, top stride and base, largest and empty formats
    load_setting(8191, 8191, 16383, 24'hffffff, 9'h1ff, 9'h000, $urandom_range(0, 511));
    random_phase(200);

    // empty frame: every point clipped
    load_setting(0, 0, 0, 0, 9'h00f, 9'h10f, 9'h008);
    random_phase(150);

    // small frame, random layout, no idling on either side
    src_gaps_on = 1'b0;
    stall_level = 0;
    load_setting($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 16383),
                 $urandom_range(0, 24'hffffff), $urandom_range(0, 511), $urandom_range(0, 511),
                 $urandom_range(0, 511));
    random_phase(200);

    // full-width register words, upper bits must be dropped
    src_gaps_on = 1'b1;
    stall_level = 1;
    load_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(150);

    // small frame again with heavy sink stalls
    stall_level = 2;
    load_setting($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 128),
                 $urandom_range(0, 24'hffffff), $urandom_range(0, 511), $urandom_range(0, 511),
                 $urandom_range(0, 511));
    random_phase(150);

    // back to reset values
    stall_level = 1;
    load_setting(FRAME_WIDTH_RST, FRAME_HEIGHT_RST, ROW_STRIDE_RST, BASE_OFFSET_RST,
                 RED_FORMAT_RST, GREEN_FORMAT_RST, BLUE_FORMAT_RST);
    random_phase(150);

    drain(20);
    if (expected_pixels.size() != 0) begin
      $error("%0d pixel items never arrived", expected_pixels.size());
      errors++;
    end
    $display("Walked %0d lines over %0d register settings; %0d pixels checked, %0d clipped.",
             lines_started, settings_used, pixels_checked, clipped_pixels);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
